FILE: src/tlh_pkg.sv
// Package for the thresholded label histogram.
// Holds the operation codes, register indexes, the back-end state type and the command word.
// No dependencies.
package tlh_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM      = 2'd0,
    OP_READ_LABEL = 2'd1,
    OP_READ_TOTAL = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM
  } back_state_e;

  localparam logic REG_THRESHOLD    = 1'b0;
  localparam logic REG_VOXEL_VOLUME = 1'b1;

  localparam logic [31:0] VOXEL_VOLUME_RESET = 32'h0001_0000;

  typedef struct packed {
    op_e         op;
    logic [15:0] label;
    logic        in_range;
    logic        hit;
  } cmd_t;

endpackage

FILE: src/thresholded_label_histogram.sv
// Top level of the thresholded label histogram: APB register block, front end and back end.
// Depends on tlh_pkg, tlh_front and tlh_back.
// A label read passes the queue, back-end states IDLE, READ, MUL and SUM and the registered
// result strobe; a total read skips READ. An accumulate passes IDLE and READ, and both it and a
// label read skip READ for a label outside the table. A two-entry queue decouples start.
// Reset, like a clear, sweeps every store entry with busy high; results cannot be stalled.
module thresholded_label_histogram import tlh_pkg::*; #(
  parameter int LABEL_COUNT = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] seg_value_i,
  input  logic [15:0] atlas_label_i,
  output logic        result_valid_o,
  output logic [15:0] label_o,
  output logic        present_o,
  output logic [31:0] count_o,
  output logic [63:0] volume_o,
  output logic        label_overflow_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] threshold_q;
  logic [31:0] voxel_volume_q;
  logic        cfg_write;
  logic        accept;
  logic        q_full;
  logic        clearing;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= 16'd0;
      voxel_volume_q <= VOXEL_VOLUME_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD:    threshold_q    <= pwdata[15:0];
        REG_VOXEL_VOLUME: voxel_volume_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:    prdata = {16'd0, threshold_q};
      REG_VOXEL_VOLUME: prdata = voxel_volume_q;
      default:          prdata = 32'd0;
    endcase
  end

  assign busy   = q_full || clearing;
  assign accept = start && !busy;

  tlh_front #(
    .LABEL_COUNT (LABEL_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_i),
    .seg_value_i   (seg_value_i),
    .atlas_label_i (atlas_label_i),
    .threshold_i   (threshold_q),
    .full_o        (q_full),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  tlh_back #(
    .LABEL_COUNT (LABEL_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .voxel_volume_i   (voxel_volume_q),
    .clearing_o       (clearing),
    .result_valid_o   (result_valid_o),
    .label_o          (label_o),
    .present_o        (present_o),
    .count_o          (count_o),
    .volume_o         (volume_o),
    .label_overflow_o (label_overflow_o)
  );

endmodule

FILE: src/tlh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-label counter store. No dependencies.
module tlh_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tlh_front.sv
// Front end: classifies each accepted word and holds it in a two-entry queue.
// Depends on tlh_pkg for the command word and operation codes.
module tlh_front import tlh_pkg::*; #(
  parameter int LABEL_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] seg_value_i,
  input  logic [15:0] atlas_label_i,
  input  logic [15:0] threshold_i,
  output logic        full_o,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;

  always_comb begin
    cls.op       = op_e'(op_i);
    cls.label    = atlas_label_i;
    cls.in_range = ({1'b0, atlas_label_i} < 17'(LABEL_COUNT));
    cls.hit      = (seg_value_i > threshold_i);
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ent_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept_i) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      if (accept_i && !cmd_pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!accept_i && cmd_pop_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rptr_q];

endmodule

FILE: src/tlh_back.sv
// Back end: executes queued commands against the label store, scales counts to volumes.
// Depends on tlh_pkg and instantiates tlh_ram.
module tlh_back import tlh_pkg::*; #(
  parameter int LABEL_COUNT = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [31:0] voxel_volume_i,
  output logic        clearing_o,
  output logic        result_valid_o,
  output logic [15:0] label_o,
  output logic        present_o,
  output logic [31:0] count_o,
  output logic [63:0] volume_o,
  output logic        label_overflow_o
);

  localparam int AW   = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
  localparam int CW   = COUNT_WIDTH;
  localparam int HALF = (CW + 1) / 2;
  localparam int HW   = CW - HALF;
  localparam int PW   = CW + 32;
  localparam int SW   = (PW > 64) ? PW : 65;
  localparam int EW   = (CW > 32) ? CW : 33;

  back_state_e state_q, state_d;

  logic [AW-1:0]      clr_addr_q;
  cmd_t               cur_q;
  logic [CW-1:0]      cnt_q;
  logic               pres_q;
  logic [CW-1:0]      total_q;
  logic               any_q;
  logic               ovf_q;
  logic [HALF+31:0]   prod_lo_q;
  logic [HW+31:0]     prod_hi_q;

  logic               res_valid_q;
  logic [15:0]        res_label_q;
  logic               res_present_q;
  logic [31:0]        res_count_q;
  logic [63:0]        res_volume_q;
  logic               res_ovf_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CW:0]        ram_wdata;
  logic [CW:0]        ram_rdata;
  logic [CW-1:0]      rd_cnt;
  logic [CW-1:0]      cnt_inc;
  logic [CW-1:0]      total_inc;
  logic [SW-1:0]      sum;
  logic [EW-1:0]      cnt_ext;

  tlh_ram #(
    .WIDTH (CW + 1),
    .DEPTH (LABEL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cmd_i.label[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_cnt    = ram_rdata[CW-1:0];
  assign cnt_inc   = (&rd_cnt) ? rd_cnt : rd_cnt + CW'(1);
  assign total_inc = (&total_q) ? total_q : total_q + CW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == AW'(LABEL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_ACCUM:      state_d = cmd_i.in_range ? ST_READ : ST_IDLE;
            OP_READ_LABEL: state_d = cmd_i.in_range ? ST_READ : ST_MUL;
            OP_READ_TOTAL: state_d = ST_MUL;
            OP_CLEAR:      state_d = ST_CLEAR;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = (cur_q.op == OP_ACCUM) ? ST_IDLE : ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_q.label[AW-1:0];
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
      end
      ST_IDLE: cmd_pop_o = cmd_valid_i;
      ST_READ: begin
        if (cur_q.op == OP_ACCUM) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, cur_q.hit ? cnt_inc : rd_cnt};
        end
      end
      ST_MUL, ST_SUM: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      total_q     <= '0;
      any_q       <= 1'b0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_SUM);
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= (state_d == ST_IDLE) ? '0 : clr_addr_q + AW'(1);
        total_q    <= '0;
        any_q      <= 1'b0;
        ovf_q      <= 1'b0;
      end
      if (state_q == ST_IDLE && cmd_valid_i && cmd_i.op == OP_ACCUM && !cmd_i.in_range) begin
        ovf_q <= 1'b1;
      end
      if (state_q == ST_READ && cur_q.op == OP_ACCUM) begin
        any_q <= 1'b1;
        if (cur_q.hit) begin
          total_q <= total_inc;
        end
      end
    end
  end

  assign sum     = SW'(prod_lo_q) + (SW'(prod_hi_q) << HALF);
  assign cnt_ext = EW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cur_q  <= cmd_i;
      cnt_q  <= (cmd_i.op == OP_READ_TOTAL) ? total_q : '0;
      pres_q <= (cmd_i.op == OP_READ_TOTAL) ? any_q : 1'b0;
    end
    if (state_q == ST_READ) begin
      cnt_q  <= rd_cnt;
      pres_q <= ram_rdata[CW];
    end
    if (state_q == ST_MUL) begin
      prod_lo_q <= (HALF + 32)'(cnt_q[HALF-1:0]) * (HALF + 32)'(voxel_volume_i);
      prod_hi_q <= (HW + 32)'(cnt_q[CW-1:HALF]) * (HW + 32)'(voxel_volume_i);
    end
    if (state_q == ST_SUM) begin
      res_label_q   <= (cur_q.op == OP_READ_TOTAL) ? 16'd0 : cur_q.label;
      res_present_q <= pres_q;
      res_count_q   <= (|cnt_ext[EW-1:32]) ? 32'hFFFF_FFFF : cnt_ext[31:0];
      res_volume_q  <= (|sum[SW-1:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      res_ovf_q     <= ovf_q;
    end
  end

  assign clearing_o       = (state_q == ST_CLEAR);
  assign result_valid_o   = res_valid_q;
  assign label_o          = res_label_q;
  assign present_o        = res_present_q;
  assign count_o          = res_count_q;
  assign volume_o         = res_volume_q;
  assign label_overflow_o = res_ovf_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("Result strobe lasted more than one cycle.");

  a_no_write_in_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_SUM) |-> !ram_we)
    else $error("Label store written while a result was being computed.");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) |=> (total_q >= $past(total_q)))
    else $error("Total count decreased outside of a clear.");

  a_no_pop_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE && cmd_valid_i))
    else $error("Command taken from the queue while the back end was busy.");

endmodule
